FILE: hw/rtl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg: shared types, constants and color table functions
// Holds field widths, register indexes, the controller/datapath command and
// status bundles, and the elaboration-time color table entry functions.
// ----------------------------------------------------------------------------
package mep_pkg;

   // field and register widths
   localparam int PIXEL_W     = 10;
   localparam int COORD_W     = 32;
   localparam int ITER_W      = 9;
   localparam int BASE_W      = 9;
   localparam int ENTRY_W     = 9;
   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 3 * CHAN_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_SCALE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_RE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_IM  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_RED   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_GREEN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_BLUE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ITER   = 3'd6;

   // register reset values
   localparam logic [COORD_W-1:0] INV_SCALE_RESET = 32'd4294967;
   localparam logic [ITER_W-1:0]  MAX_ITER_RESET  = 9'd377;

   // Q4.28 constants and the pixel center
   localparam logic signed [47:0] Q_TWO_HALF    = 48'sd671088640;
   localparam logic signed [47:0] Q_ONE_QUARTER = 48'sd335544320;
   localparam logic [PIXEL_W:0]   Q_CENTER      = 11'd500;

   // color table phase steps (turn phases) and sine polynomial
   localparam logic [31:0] STEP_R  = 32'd68356528;
   localparam logic [31:0] STEP_G  = 32'd136713055;
   localparam logic [31:0] STEP_B1 = 32'd205069583;
   localparam logic [31:0] STEP_B2 = 32'd273426110;
   localparam logic [63:0] POLY_A  = 64'd1686629713;
   localparam logic [63:0] POLY_B  = 64'd693598564;
   localparam logic [63:0] POLY_C  = 64'd80710675;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic setup;
      logic multiply;
      logic update;
      logic fetch;
      logic shade;
   } mep_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic finish;
   } mep_status_type;

   // quarter-wave sine polynomial, Q30 in and out
   function automatic logic [63:0] quarter_sine(input logic [63:0] t);
      logic [63:0] t2;
      logic [63:0] inner;
      logic [63:0] mid;
      t2    = (t * t) >> 30;
      inner = POLY_B - ((t2 * POLY_C) >> 30);
      mid   = POLY_A - ((t2 * inner) >> 30);
      return (t * mid) >> 30;
   endfunction

   // sine of a 32-bit turn phase, Q30
   function automatic logic signed [63:0] sin_q30(input logic [31:0] phase);
      logic [63:0] t;
      logic [63:0] s;
      t = {34'd0, phase[29:0]};
      if (phase[30]) begin
         s = quarter_sine(Q30_ONE - t);
      end else begin
         s = quarter_sine(t);
      end
      return phase[31] ? -$signed(s) : $signed(s);
   endfunction

   function automatic logic signed [63:0] cos_q30(input logic [31:0] phase);
      return sin_q30(phase + 32'h4000_0000);
   endfunction

   // table index times step, wrapped at one turn
   function automatic logic [31:0] phase_of(input logic [31:0] idx, input logic [31:0] step);
      logic [63:0] p;
      p = 64'(idx) * 64'(step);
      return p[31:0];
   endfunction

   function automatic logic signed [ENTRY_W-1:0] red_entry(input logic [31:0] idx);
      logic signed [63:0] v;
      v = (sin_q30(phase_of(idx, STEP_R)) <<< 7) + (64'sd1 <<< 29);
      v = v >>> 30;
      return $signed(v[ENTRY_W-1:0]);
   endfunction

   function automatic logic signed [ENTRY_W-1:0] green_entry(input logic [31:0] idx);
      logic signed [63:0] v;
      v = (cos_q30(phase_of(idx, STEP_G)) <<< 7) + (64'sd1 <<< 29);
      v = v >>> 30;
      return $signed(v[ENTRY_W-1:0]);
   endfunction

   function automatic logic signed [ENTRY_W-1:0] blue_entry(input logic [31:0] idx);
      logic signed [63:0] v;
      v = sin_q30(phase_of(idx, STEP_B1)) * cos_q30(phase_of(idx, STEP_B2));
      v = (v + (64'sd1 <<< 52)) >>> 53;
      return $signed(v[ENTRY_W-1:0]);
   endfunction

endpackage

FILE: hw/rtl/mep_req_if.sv
// ----------------------------------------------------------------------------
// mep_req_if: pixel request channel
// Valid/ready channel carrying one pixel coordinate per transaction.
// ----------------------------------------------------------------------------
interface mep_req_if;
   import mep_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_x;
   logic [PIXEL_W-1:0] pixel_y;

   modport source(output valid, output pixel_x, output pixel_y, input ready);
   modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

FILE: hw/rtl/mep_rsp_if.sv
// ----------------------------------------------------------------------------
// mep_rsp_if: pixel result channel
// Valid/ready channel carrying the color and iteration count per transaction.
// ----------------------------------------------------------------------------
interface mep_rsp_if;
   import mep_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] color;
   logic [ITER_W-1:0]  iterations;

   modport source(output valid, output color, output iterations, input ready);
   modport sink(input valid, input color, input iterations, output ready);
endinterface

FILE: hw/rtl/mep_ctrl.sv
// ----------------------------------------------------------------------------
// mep_ctrl: pixel sequencer
// State machine that steps one pixel through setup, the escape loop, the
// color fetch and the result load, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mep_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mep_pkg::mep_status_type status,
   output mep_pkg::mep_cmd_type    cmd
);
   import mep_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_UPD   = 3'd3;
   localparam logic [2:0] ST_FETCH = 3'd4;
   localparam logic [2:0] ST_SHADE = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       valid_ff;
   logic       valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   // sequence the pixel and drive the datapath
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cmd      = '0;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            if (status.finish) begin
               state_in = ST_FETCH;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SHADE;
         end
         ST_SHADE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.shade = 1'b1;
               valid_in  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // a result is loaded only into a free or draining output register
   a_shade_free: assert property (@(posedge clock) disable iff (reset)
      cmd.shade |-> (!valid_ff || rsp_ready))
      else $error("result loaded over a pending transaction");

endmodule

FILE: hw/rtl/mep_dpath.sv
// ----------------------------------------------------------------------------
// mep_dpath: escape-time datapath
// Maps the pixel to c and the starting z, then runs z = z*z + c, one
// iteration per multiply/update pair, counting iterations and table index.
// ----------------------------------------------------------------------------
module mep_dpath #(
   parameter int  COLOR_TABLE_DEPTH = 512,
   localparam int IDX_W             = $clog2(COLOR_TABLE_DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mep_pkg::mep_cmd_type                cmd,
   input  logic [mep_pkg::PIXEL_W-1:0]         pixel_x,
   input  logic [mep_pkg::PIXEL_W-1:0]         pixel_y,
   input  logic [mep_pkg::COORD_W-1:0]         inv_scale,
   input  logic signed [mep_pkg::COORD_W-1:0]  offset_re,
   input  logic signed [mep_pkg::COORD_W-1:0]  offset_im,
   input  logic [mep_pkg::ITER_W-1:0]          max_iter,
   output mep_pkg::mep_status_type             status,
   output logic [mep_pkg::ITER_W-1:0]          count,
   output logic [IDX_W-1:0]                    index
);
   import mep_pkg::*;

   localparam int PROD_W = PIXEL_W + COORD_W;
   localparam int DIFF_W = PROD_W + 1;
   localparam int WIDE_W = 48;

   // saturate a wide signed value to the Q4.28 range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(32'sh7FFF_FFFF);
      lo = -(WIDE_W'(32'sh7FFF_FFFF)) - WIDE_W'(1);
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[COORD_W-1:0];
   endfunction

   logic [PROD_W-1:0]         prod_x_ff;
   logic [PROD_W-1:0]         prod_y_ff;
   logic signed [DIFF_W-1:0]  cent_x_ff;
   logic signed [DIFF_W-1:0]  cent_y_ff;
   logic signed [COORD_W-1:0] cre_ff;
   logic signed [COORD_W-1:0] cim_ff;
   logic signed [COORD_W-1:0] zx_ff;
   logic signed [COORD_W-1:0] zy_ff;
   logic signed [COORD_W-1:0] zx_in;
   logic signed [COORD_W-1:0] zy_in;
   logic [63:0]               sx_ff;
   logic [63:0]               sy_ff;
   logic signed [63:0]        pxy_ff;
   logic [COORD_W-1:0]        ax;
   logic [COORD_W-1:0]        ay;
   logic [63:0]               mag;
   logic signed [64:0]        sq_diff;
   logic                      escaped;
   logic                      limited;
   logic [ITER_W-1:0]         count_ff;
   logic [IDX_W-1:0]          k_ff;
   logic [IDX_W-1:0]          k_in;
   logic signed [PIXEL_W:0]   dx;
   logic signed [PIXEL_W:0]   dy;

   // capture: scale the pixel, both relative to zero and to the center
   assign dx = $signed({1'b0, pixel_x}) - $signed(Q_CENTER);
   assign dy = $signed({1'b0, pixel_y}) - $signed(Q_CENTER);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_x_ff <= PROD_W'(pixel_x) * PROD_W'(inv_scale);
         prod_y_ff <= PROD_W'(pixel_y) * PROD_W'(inv_scale);
         cent_x_ff <= DIFF_W'(dx) * $signed({{(DIFF_W-COORD_W){1'b0}}, inv_scale});
         cent_y_ff <= DIFF_W'(dy) * $signed({{(DIFF_W-COORD_W){1'b0}}, inv_scale});
      end
   end

   // iteration: magnitudes of z for the squares
   assign ax = zx_ff[COORD_W-1] ? COORD_W'(-zx_ff) : zx_ff;
   assign ay = zy_ff[COORD_W-1] ? COORD_W'(-zy_ff) : zy_ff;

   // escape test on the registered squares, limit test on the count
   assign mag     = sx_ff + sy_ff;
   assign escaped = |mag[63:58];
   assign limited = (count_ff >= max_iter);
   assign status.finish = escaped || limited;

   // next z from the registered products
   assign sq_diff = $signed({1'b0, sx_ff}) - $signed({1'b0, sy_ff});
   assign zx_in = sat_coord($signed({{(WIDE_W-37){sq_diff[64]}}, sq_diff[64:28]})
                            + WIDE_W'(cre_ff));
   assign zy_in = sat_coord($signed({{(WIDE_W-37){pxy_ff[63]}}, pxy_ff[63:27]})
                            + WIDE_W'(cim_ff));

   // advance the table index, wrapping at the table depth
   assign k_in = (k_ff == IDX_W'(COLOR_TABLE_DEPTH - 1)) ? '0 : k_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      // setup: c and the starting z
      if (cmd.setup) begin
         cre_ff <= sat_coord($signed({{(WIDE_W-PROD_W+4){1'b0}}, prod_x_ff[PROD_W-1:4]})
                             - Q_TWO_HALF);
         cim_ff <= sat_coord($signed({{(WIDE_W-PROD_W+4){1'b0}}, prod_y_ff[PROD_W-1:4]})
                             - Q_ONE_QUARTER);
         zx_ff  <= sat_coord(WIDE_W'(offset_re)
                             + $signed({{(WIDE_W-DIFF_W+4){cent_x_ff[DIFF_W-1]}},
                                        cent_x_ff[DIFF_W-1:4]}));
         zy_ff  <= sat_coord(WIDE_W'(offset_im)
                             + $signed({{(WIDE_W-DIFF_W+4){cent_y_ff[DIFF_W-1]}},
                                        cent_y_ff[DIFF_W-1:4]}));
      end else if (cmd.update) begin
         zx_ff <= zx_in;
         zy_ff <= zy_in;
      end
      // multiply: squares and cross product of z
      if (cmd.multiply) begin
         sx_ff  <= 64'(ax) * 64'(ax);
         sy_ff  <= 64'(ay) * 64'(ay);
         pxy_ff <= 64'(zx_ff) * 64'(zy_ff);
      end
   end

   // iteration count and table index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         k_ff     <= '0;
      end else if (cmd.setup) begin
         count_ff <= '0;
         k_ff     <= '0;
      end else if (cmd.update) begin
         count_ff <= count_ff + ITER_W'(1);
         k_ff     <= k_in;
      end
   end

   assign count = count_ff;
   assign index = k_ff;

   // never iterate past the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (count_ff < max_iter))
      else $error("iteration beyond max_iter");

   // each update adds exactly one to the count
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (count_ff == $past(count_ff) + ITER_W'(1)))
      else $error("iteration count did not advance by one");

   // table index wraps to zero at the last entry
   a_index_wrap: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && k_ff == IDX_W'(COLOR_TABLE_DEPTH - 1)) |=> (k_ff == '0))
      else $error("color table index failed to wrap");

endmodule

FILE: hw/rtl/mep_color.sv
// ----------------------------------------------------------------------------
// mep_color: color table and result register
// Reads the three channel tables at the final index, adds the base values,
// clamps each channel to 0..255 and loads the result register.
// ----------------------------------------------------------------------------
module mep_color #(
   parameter int  COLOR_TABLE_DEPTH = 512,
   localparam int IDX_W             = $clog2(COLOR_TABLE_DEPTH)
) (
   input  logic                               clock,
   input  mep_pkg::mep_cmd_type               cmd,
   input  logic [IDX_W-1:0]                   index,
   input  logic [mep_pkg::ITER_W-1:0]         count,
   input  logic signed [mep_pkg::BASE_W-1:0]  base_red,
   input  logic signed [mep_pkg::BASE_W-1:0]  base_green,
   input  logic signed [mep_pkg::BASE_W-1:0]  base_blue,
   output logic [mep_pkg::COLOR_W-1:0]        color,
   output logic [mep_pkg::ITER_W-1:0]         iterations
);
   import mep_pkg::*;

   // base plus table entry, clamped to one channel
   function automatic logic [CHAN_W-1:0] shade_chan(input logic signed [BASE_W-1:0] base,
                                                    input logic signed [ENTRY_W-1:0] entry);
      logic signed [ENTRY_W:0] sum;
      sum = $signed({base[BASE_W-1], base}) + $signed({entry[ENTRY_W-1], entry});
      if (sum[ENTRY_W]) begin
         return '0;
      end else if (sum[ENTRY_W-1]) begin
         return '1;
      end
      return sum[CHAN_W-1:0];
   endfunction

   logic signed [ENTRY_W-1:0] red_rom   [COLOR_TABLE_DEPTH];
   logic signed [ENTRY_W-1:0] green_rom [COLOR_TABLE_DEPTH];
   logic signed [ENTRY_W-1:0] blue_rom  [COLOR_TABLE_DEPTH];
   logic signed [ENTRY_W-1:0] red_ff;
   logic signed [ENTRY_W-1:0] green_ff;
   logic signed [ENTRY_W-1:0] blue_ff;
   logic [COLOR_W-1:0]        color_ff;
   logic [ITER_W-1:0]         iter_ff;

   // table contents fixed at elaboration
   for (genvar i = 0; i < COLOR_TABLE_DEPTH; i++) begin : g_rom
      localparam logic signed [ENTRY_W-1:0] RED_V   = red_entry(32'(i));
      localparam logic signed [ENTRY_W-1:0] GREEN_V = green_entry(32'(i));
      localparam logic signed [ENTRY_W-1:0] BLUE_V  = blue_entry(32'(i));
      assign red_rom[i]   = RED_V;
      assign green_rom[i] = GREEN_V;
      assign blue_rom[i]  = BLUE_V;
   end

   // registered table read
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         red_ff   <= red_rom[index];
         green_ff <= green_rom[index];
         blue_ff  <= blue_rom[index];
      end
   end

   // load the result register
   always_ff @(posedge clock) begin
      if (cmd.shade) begin
         color_ff <= {shade_chan(base_red, red_ff),
                      shade_chan(base_green, green_ff),
                      shade_chan(base_blue, blue_ff)};
         iter_ff  <= count;
      end
   end

   assign color      = color_ff;
   assign iterations = iter_ff;

endmodule

FILE: hw/rtl/mandelbrot_escape_pixel_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top: escape-time Mandelbrot pixel engine
// Channel   Dir  Payload                            Handshake
// req_if    in   pixel_x[9:0], pixel_y[9:0]         valid/ready
// rsp_if    out  color[23:0], iterations[8:0]       valid/ready
// csr_*     in   csr_index[2:0], csr_wr_data[31:0]  csr_wr_en, no back-pressure
//
// A pixel steps through capture, setup, the escape loop, the color fetch and
// the result load; the next pixel is accepted once the sequencer is idle
// again. The escape loop sets the time per pixel: each iteration is a multiply
// step of three 32x32 multiplies and an update step of add, saturate and test.
// Reset is synchronous: configuration returns to defaults, no result pending.
// The result register holds until taken; a new pixel is accepted while it
// waits, and a finished pixel waits for the register to be taken.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top #(
   parameter int COLOR_TABLE_DEPTH = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   mep_req_if.sink                            req_if,
   mep_rsp_if.source                          rsp_if,
   input  logic                               csr_wr_en,
   input  logic [mep_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mep_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import mep_pkg::*;

   localparam int IDX_W = $clog2(COLOR_TABLE_DEPTH);

   logic [COORD_W-1:0]        inv_scale_ff;
   logic signed [COORD_W-1:0] offset_re_ff;
   logic signed [COORD_W-1:0] offset_im_ff;
   logic signed [BASE_W-1:0]  base_red_ff;
   logic signed [BASE_W-1:0]  base_green_ff;
   logic signed [BASE_W-1:0]  base_blue_ff;
   logic [ITER_W-1:0]         max_iter_ff;

   mep_cmd_type               cmd;
   mep_status_type            status;
   logic [ITER_W-1:0]         count;
   logic [IDX_W-1:0]          index;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_scale_ff  <= INV_SCALE_RESET;
         offset_re_ff  <= '0;
         offset_im_ff  <= '0;
         base_red_ff   <= '0;
         base_green_ff <= '0;
         base_blue_ff  <= '0;
         max_iter_ff   <= MAX_ITER_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INV_SCALE:  inv_scale_ff  <= csr_wr_data;
            CSR_OFFSET_RE:  offset_re_ff  <= csr_wr_data;
            CSR_OFFSET_IM:  offset_im_ff  <= csr_wr_data;
            CSR_BASE_RED:   base_red_ff   <= csr_wr_data[BASE_W-1:0];
            CSR_BASE_GREEN: base_green_ff <= csr_wr_data[BASE_W-1:0];
            CSR_BASE_BLUE:  base_blue_ff  <= csr_wr_data[BASE_W-1:0];
            CSR_MAX_ITER:   max_iter_ff   <= csr_wr_data[ITER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mep_dpath #(
      .COLOR_TABLE_DEPTH (COLOR_TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .pixel_x   (req_if.pixel_x),
      .pixel_y   (req_if.pixel_y),
      .inv_scale (inv_scale_ff),
      .offset_re (offset_re_ff),
      .offset_im (offset_im_ff),
      .max_iter  (max_iter_ff),
      .status    (status),
      .count     (count),
      .index     (index)
   );

   mep_color #(
      .COLOR_TABLE_DEPTH (COLOR_TABLE_DEPTH)
   ) u_color (
      .clock      (clock),
      .cmd        (cmd),
      .index      (index),
      .count      (count),
      .base_red   (base_red_ff),
      .base_green (base_green_ff),
      .base_blue  (base_blue_ff),
      .color      (rsp_if.color),
      .iterations (rsp_if.iterations)
   );

endmodule
